// File: hdl/kfsl_pkg.sv
package kfsl_pkg;

	localparam int MAX_KEYS = 256;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int TIME_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int QUO_W    = FRAC_W + 1;
	localparam int STEP_W   = 6;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// one request on the command channel
	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] key_time;
		logic [7:0]        key_index;
		logic [TIME_W-1:0] query_time;
	} req_t;

	// one result on the result channel
	typedef struct packed {
		logic [1:0]        status;
		logic [7:0]        first_index;
		logic [7:0]        second_index;
		logic [FRAC_W-1:0] fraction;
		logic [8:0]        key_count;
	} rsp_t;

	// launch of the shared divider
	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] rem_init;
		logic [TIME_W-1:0] dividend;
		logic [TIME_W:0]   divisor;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
	} div_res_t;

endpackage

// File: hdl/keyframe_segment_locator.sv
// Sorted keyframe time table with a bracketing lookup. A request is taken
// when start is high and busy is low; its result appears on rsp for exactly
// one cycle with done high and cannot be stalled, so the receiver must take
// it then. The times sit in a 256-entry memory with one write and one read
// port and a registered read, and insert, remove and lookup walk it one
// access at a time. Insert moves each larger entry up one place, remove
// moves the entries above it down one place, and clear and every error
// finish without touching the memory. Lookup runs a binary search (at most
// 9 steps), reads the bracket, runs the shared divider for the fraction when
// it is not zero, and first wraps the query by the clip length when it must.
// Clip length is written over the APB port at offset 0 and should only be
// changed while the block is idle.
module keyframe_segment_locator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  kfsl_pkg::req_t      req,
	output logic                done,
	output kfsl_pkg::rsp_t      rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_INS_RD = 11'b000_0000_0010,
		S_INS_WR = 11'b000_0000_0100,
		S_REM_RD = 11'b000_0000_1000,
		S_REM_WR = 11'b000_0001_0000,
		S_MOD    = 11'b000_0010_0000,
		S_BS_RD  = 11'b000_0100_0000,
		S_BS_CMP = 11'b000_1000_0000,
		S_T2_RD  = 11'b001_0000_0000,
		S_T2_GET = 11'b010_0000_0000,
		S_T1_GET = 11'b100_0000_0000
	} state_t;

	localparam int CW = kfsl_pkg::CNT_W;
	localparam int IW = kfsl_pkg::IDX_W;
	localparam int TW = kfsl_pkg::TIME_W;

	state_t                state_q;
	logic                  frac_wait_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         i_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         hi_q;
	logic [CW-1:0]         sec_q;
	logic [CW-1:0]         f_q;
	logic [TW-1:0]         kt_q;
	logic [TW-1:0]         q_q;
	logic [TW:0]           t2_q;
	logic [TW-1:0]         clip_q;
	logic [1:0]            status_q;
	logic [7:0]            first_q;
	logic [7:0]            second_q;
	logic [15:0]           frac_q;
	logic                  done_q;

	logic [TW-1:0]         mem [kfsl_pkg::MAX_KEYS];
	logic [TW-1:0]         rd_q;
	logic                  we;
	logic [IW-1:0]         wa;
	logic [TW-1:0]         wd;
	logic [IW-1:0]         ra;

	logic [CW:0]           mid_sum;
	logic [CW-1:0]         mid;
	logic                  at_end;
	logic [CW-1:0]         f_c;
	logic [TW:0]           t2_c;
	logic [TW-1:0]         qdiff;
	logic                  need_wrap;
	logic                  frac_zero;
	kfsl_pkg::div_cmd_t    div_cmd;
	kfsl_pkg::div_res_t    div_res;
	logic                  cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 32'd65536;
		end else if (cfg_wr) begin
			clip_q <= pwdata;
		end
	end

	// key time memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// search and bracket helpers
	always_comb begin
		mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
		mid       = mid_sum[CW:1];
		at_end    = (lo_q == cnt_q);
		need_wrap = (clip_q != '0) && (req.query_time > clip_q);
		if (at_end) begin
			f_c  = cnt_q - 1'b1;
			t2_c = {1'b0, clip_q} + {1'b0, rd_q};
		end else begin
			f_c  = ((lo_q != '0) && (q_q < rd_q)) ? lo_q - 1'b1 : lo_q;
			t2_c = {1'b0, rd_q};
		end
		qdiff     = q_q - rd_q;
		frac_zero = (t2_q <= {1'b0, rd_q}) || (q_q <= rd_q);
	end

	// memory access per state
	always_comb begin
		we = 1'b0;
		wa = i_q[IW-1:0];
		wd = rd_q;
		ra = '0;
		case (state_q)
			S_INS_RD: begin
				ra = IW'(i_q - 1'b1);
				if (i_q == '0) begin
					we = 1'b1;
					wd = kt_q;
				end
			end
			S_INS_WR: begin
				we = 1'b1;
				wd = (rd_q > kt_q) ? rd_q : kt_q;
			end
			S_REM_RD: ra = IW'(i_q + 1'b1);
			S_REM_WR: we = 1'b1;
			S_BS_RD:  ra = mid[IW-1:0];
			S_T2_RD:  ra = at_end ? '0 : lo_q[IW-1:0];
			S_T2_GET: ra = f_c[IW-1:0];
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// divider launch: wrap of the query, then the fraction
	always_comb begin
		div_cmd = '0;
		if (state_q == S_IDLE && start && !frac_wait_q && req.op == kfsl_pkg::OP_LOOKUP
				&& cnt_q != '0 && need_wrap) begin
			div_cmd.start    = 1'b1;
			div_cmd.dividend = req.query_time;
			div_cmd.divisor  = {1'b0, clip_q};
			div_cmd.steps    = kfsl_pkg::STEP_W'(TW);
		end else if (state_q == S_T1_GET && !frac_zero) begin
			div_cmd.start    = 1'b1;
			div_cmd.rem_init = {1'b0, qdiff[TW-1:1]};
			div_cmd.dividend = {qdiff[0], {(TW-1){1'b0}}};
			div_cmd.divisor  = t2_q - {1'b0, rd_q};
			div_cmd.steps    = kfsl_pkg::STEP_W'(kfsl_pkg::QUO_W);
		end
	end

	kfsl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frac_wait_q <= 1'b0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && !frac_wait_q) begin
						status_q <= kfsl_pkg::ST_OK;
						first_q  <= '0;
						second_q <= '0;
						frac_q   <= '0;
						kt_q     <= req.key_time;
						q_q      <= req.query_time;
						lo_q     <= '0;
						hi_q     <= cnt_q;
						case (req.op)
							kfsl_pkg::OP_INSERT: begin
								if (cnt_q == CW'(kfsl_pkg::MAX_KEYS)) begin
									status_q <= kfsl_pkg::ST_FULL;
									done_q   <= 1'b1;
								end else begin
									i_q     <= cnt_q;
									state_q <= S_INS_RD;
								end
							end
							kfsl_pkg::OP_REMOVE: begin
								if (CW'(req.key_index) >= cnt_q) begin
									status_q <= kfsl_pkg::ST_RANGE;
									done_q   <= 1'b1;
								end else begin
									i_q     <= CW'(req.key_index);
									state_q <= S_REM_RD;
								end
							end
							kfsl_pkg::OP_CLEAR: begin
								cnt_q  <= '0;
								done_q <= 1'b1;
							end
							default: begin
								if (cnt_q == '0) begin
									status_q <= kfsl_pkg::ST_EMPTY;
									done_q   <= 1'b1;
								end else if (need_wrap) begin
									state_q <= S_MOD;
								end else begin
									state_q <= S_BS_RD;
								end
							end
						endcase
					end else if (frac_wait_q && div_res.done) begin
						frac_wait_q <= 1'b0;
						frac_q      <= div_res.quo[kfsl_pkg::QUO_W-1] ? 16'hFFFF
						               : div_res.quo[15:0];
						done_q      <= 1'b1;
					end
				end
				// walk down moving larger entries up one place
				S_INS_RD: begin
					if (i_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					if (rd_q > kt_q) begin
						i_q     <= i_q - 1'b1;
						state_q <= S_INS_RD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				// walk up moving entries down one place
				S_REM_RD: begin
					if (CW'(i_q + 1'b1) >= cnt_q) begin
						cnt_q   <= cnt_q - 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_REM_WR;
					end
				end
				S_REM_WR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_REM_RD;
				end
				S_MOD: begin
					if (div_res.done) begin
						q_q     <= div_res.rem;
						state_q <= S_BS_RD;
					end
				end
				// lower bound search
				S_BS_RD: begin
					f_q <= mid;
					if (lo_q < hi_q) begin
						state_q <= S_BS_CMP;
					end else begin
						state_q <= S_T2_RD;
					end
				end
				S_BS_CMP: begin
					if (rd_q < q_q) begin
						lo_q <= f_q + 1'b1;
					end else begin
						hi_q <= f_q;
					end
					state_q <= S_BS_RD;
				end
				S_T2_RD: begin
					sec_q   <= at_end ? '0 : lo_q;
					state_q <= S_T2_GET;
				end
				S_T2_GET: begin
					t2_q     <= t2_c;
					f_q      <= f_c;
					first_q  <= f_c[7:0];
					second_q <= sec_q[7:0];
					state_q  <= S_T1_GET;
				end
				S_T1_GET: begin
					state_q <= S_IDLE;
					if (frac_zero) begin
						done_q <= 1'b1;
					end else begin
						frac_wait_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// handshake and result
	assign busy = (state_q != S_IDLE) || frac_wait_q;
	assign done = done_q;
	assign rsp  = '{status: status_q, first_index: first_q, second_index: second_q,
	                fraction: frac_q, key_count: cnt_q};

endmodule

// File: hdl/kfsl_div.sv
module kfsl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  kfsl_pkg::div_cmd_t  cmd,
	output kfsl_pkg::div_res_t  res
);

	logic [kfsl_pkg::TIME_W:0]   rem_q;
	logic [kfsl_pkg::TIME_W-1:0] dvd_q;
	logic [kfsl_pkg::TIME_W:0]   dsr_q;
	logic [kfsl_pkg::QUO_W-1:0]  quo_q;
	logic [kfsl_pkg::STEP_W-1:0] step_q;
	logic                        run_q;
	logic                        done_q;
	logic [kfsl_pkg::TIME_W+1:0] shifted;
	logic [kfsl_pkg::TIME_W+1:0] diff;
	logic                        fits;

	// one restoring step: shift in the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, dvd_q[kfsl_pkg::TIME_W-1]};
		diff    = shifted - {1'b0, dsr_q};
		fits    = (shifted >= {1'b0, dsr_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q  <= 1'b1;
				step_q <= cmd.steps;
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == kfsl_pkg::STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= {1'b0, cmd.rem_init};
			dvd_q <= cmd.dividend;
			dsr_q <= cmd.divisor;
			quo_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[kfsl_pkg::TIME_W-2:0], 1'b0};
			quo_q <= {quo_q[kfsl_pkg::QUO_W-2:0], fits};
			rem_q <= fits ? diff[kfsl_pkg::TIME_W:0] : shifted[kfsl_pkg::TIME_W:0];
		end
	end

	assign res = '{done: done_q, rem: rem_q[kfsl_pkg::TIME_W-1:0], quo: quo_q};

endmodule
